// ===== rtl/core/kf2d_pkg.sv =====
`default_nettype none
package kf2d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int QUO_W     = DATA_W + FRAC_BITS;

  localparam logic signed [DATA_W-1:0] ONE_FX   = DATA_W'(1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] TENTH_FX =
    DATA_W'(((1 << FRAC_BITS) + 5) / 10);

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TRANS_XX, CFG_TRANS_XY, CFG_TRANS_YX, CFG_TRANS_YY,
    CFG_PNOISE_X, CFG_PNOISE_Y, CFG_MNOISE_X, CFG_MNOISE_Y
  } cfg_idx_t;

  // operand / destination codes of the datapath register file
  typedef enum logic [5:0] {
    R_ONE, R_X0, R_X1, R_P0, R_P1, R_P2, R_P3,
    R_M0, R_M1, R_M2, R_M3, R_S0, R_S1, R_S2, R_S3,
    R_K0, R_K1, R_K2, R_K3, R_Y0, R_Y1, R_DET, R_N, R_Z0, R_Z1,
    R_A0, R_A1, R_A2, R_A3, R_QX, R_QY, R_RX, R_RY
  } sel_t;

  typedef enum logic [2:0] {
    U_ACC, U_KDIV, U_BR_NODET, U_BR_SING, U_END
  } ukind_t;

  // one microcode word: up to three product terms summed, then stored
  typedef struct packed {
    ukind_t     kind;
    logic [1:0] nterm;
    sel_t       a0;
    sel_t       b0;
    sel_t       a1;
    sel_t       b1;
    sel_t       a2;
    sel_t       b2;
    logic [2:0] sub;
    sel_t       dst;
  } uop_t;

  typedef logic [5:0] upc_t;
  localparam upc_t UPC_END = 6'd41;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic mac_en;
    logic mac_clr;
    logic mac_sub;
    sel_t sel_a;
    sel_t sel_b;
    logic st_en;
    sel_t wr_sel;
    logic div_go;
    logic sing_set;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic det_req;
    logic det_zero;
    logic div_done;
  } dp_sts_t;

  function automatic uop_t mk(ukind_t k, logic [1:0] n, sel_t a0, sel_t b0,
                              sel_t a1, sel_t b1, sel_t a2, sel_t b2,
                              logic [2:0] sb, sel_t d);
    uop_t u;
    u.kind = k; u.nterm = n;
    u.a0 = a0; u.b0 = b0; u.a1 = a1; u.b1 = b1; u.a2 = a2; u.b2 = b2;
    u.sub = sb; u.dst = d;
    return u;
  endfunction

  function automatic uop_t ucode(upc_t pc);
    uop_t u;
    u = mk(U_END, 2'd0, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b000, R_ONE);
    case (pc)
      // predict state, via temporaries
      6'd0:  u = mk(U_ACC, 2'd2, R_A0, R_X0, R_A1, R_X1, R_ONE, R_ONE, 3'b000, R_M0);
      6'd1:  u = mk(U_ACC, 2'd2, R_A2, R_X0, R_A3, R_X1, R_ONE, R_ONE, 3'b000, R_M1);
      6'd2:  u = mk(U_ACC, 2'd1, R_M0, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b000, R_X0);
      6'd3:  u = mk(U_ACC, 2'd1, R_M1, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b000, R_X1);
      // M = A*P
      6'd4:  u = mk(U_ACC, 2'd2, R_A0, R_P0, R_A1, R_P2, R_ONE, R_ONE, 3'b000, R_M0);
      6'd5:  u = mk(U_ACC, 2'd2, R_A0, R_P1, R_A1, R_P3, R_ONE, R_ONE, 3'b000, R_M1);
      6'd6:  u = mk(U_ACC, 2'd2, R_A2, R_P0, R_A3, R_P2, R_ONE, R_ONE, 3'b000, R_M2);
      6'd7:  u = mk(U_ACC, 2'd2, R_A2, R_P1, R_A3, R_P3, R_ONE, R_ONE, 3'b000, R_M3);
      // P = M*A'
      6'd8:  u = mk(U_ACC, 2'd2, R_M0, R_A0, R_M1, R_A1, R_ONE, R_ONE, 3'b000, R_P0);
      6'd9:  u = mk(U_ACC, 2'd2, R_M0, R_A2, R_M1, R_A3, R_ONE, R_ONE, 3'b000, R_P1);
      6'd10: u = mk(U_ACC, 2'd2, R_M2, R_A0, R_M3, R_A1, R_ONE, R_ONE, 3'b000, R_P2);
      6'd11: u = mk(U_ACC, 2'd2, R_M2, R_A2, R_M3, R_A3, R_ONE, R_ONE, 3'b000, R_P3);
      // P += Q
      6'd12: u = mk(U_ACC, 2'd2, R_P0, R_ONE, R_QX, R_ONE, R_ONE, R_ONE, 3'b000, R_P0);
      6'd13: u = mk(U_ACC, 2'd2, R_P3, R_ONE, R_QY, R_ONE, R_ONE, R_ONE, 3'b000, R_P3);
      6'd14: u = mk(U_BR_NODET, 2'd0, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE,
                    3'b000, R_ONE);
      // S = P + R
      6'd15: u = mk(U_ACC, 2'd2, R_P0, R_ONE, R_RX, R_ONE, R_ONE, R_ONE, 3'b000, R_S0);
      6'd16: u = mk(U_ACC, 2'd1, R_P1, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b000, R_S1);
      6'd17: u = mk(U_ACC, 2'd1, R_P2, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b000, R_S2);
      6'd18: u = mk(U_ACC, 2'd2, R_P3, R_ONE, R_RY, R_ONE, R_ONE, R_ONE, 3'b000, R_S3);
      6'd19: u = mk(U_ACC, 2'd2, R_S0, R_S3, R_S1, R_S2, R_ONE, R_ONE, 3'b010, R_DET);
      6'd20: u = mk(U_BR_SING, 2'd0, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE,
                    3'b000, R_ONE);
      // adjugate of S into M
      6'd21: u = mk(U_ACC, 2'd1, R_S3, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b000, R_M0);
      6'd22: u = mk(U_ACC, 2'd1, R_S1, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b001, R_M1);
      6'd23: u = mk(U_ACC, 2'd1, R_S2, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b001, R_M2);
      6'd24: u = mk(U_ACC, 2'd1, R_S0, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b000, R_M3);
      // K = P*adj / det
      6'd25: u = mk(U_KDIV, 2'd2, R_P0, R_M0, R_P1, R_M2, R_ONE, R_ONE, 3'b000, R_K0);
      6'd26: u = mk(U_KDIV, 2'd2, R_P0, R_M1, R_P1, R_M3, R_ONE, R_ONE, 3'b000, R_K1);
      6'd27: u = mk(U_KDIV, 2'd2, R_P2, R_M0, R_P3, R_M2, R_ONE, R_ONE, 3'b000, R_K2);
      6'd28: u = mk(U_KDIV, 2'd2, R_P2, R_M1, R_P3, R_M3, R_ONE, R_ONE, 3'b000, R_K3);
      // innovation and state update
      6'd29: u = mk(U_ACC, 2'd2, R_Z0, R_ONE, R_X0, R_ONE, R_ONE, R_ONE, 3'b010, R_Y0);
      6'd30: u = mk(U_ACC, 2'd2, R_Z1, R_ONE, R_X1, R_ONE, R_ONE, R_ONE, 3'b010, R_Y1);
      6'd31: u = mk(U_ACC, 2'd3, R_X0, R_ONE, R_K0, R_Y0, R_K1, R_Y1, 3'b000, R_X0);
      6'd32: u = mk(U_ACC, 2'd3, R_X1, R_ONE, R_K2, R_Y0, R_K3, R_Y1, 3'b000, R_X1);
      // P - K*P into S, then copy back
      6'd33: u = mk(U_ACC, 2'd3, R_P0, R_ONE, R_K0, R_P0, R_K1, R_P2, 3'b110, R_S0);
      6'd34: u = mk(U_ACC, 2'd3, R_P1, R_ONE, R_K0, R_P1, R_K1, R_P3, 3'b110, R_S1);
      6'd35: u = mk(U_ACC, 2'd3, R_P2, R_ONE, R_K2, R_P0, R_K3, R_P2, 3'b110, R_S2);
      6'd36: u = mk(U_ACC, 2'd3, R_P3, R_ONE, R_K2, R_P1, R_K3, R_P3, 3'b110, R_S3);
      6'd37: u = mk(U_ACC, 2'd1, R_S0, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b000, R_P0);
      6'd38: u = mk(U_ACC, 2'd1, R_S1, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b000, R_P1);
      6'd39: u = mk(U_ACC, 2'd1, R_S2, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b000, R_P2);
      6'd40: u = mk(U_ACC, 2'd1, R_S3, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, 3'b000, R_P3);
      default: u = mk(U_END, 2'd0, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE, R_ONE,
                      3'b000, R_ONE);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kf2d_div.sv =====
`default_nettype none
module kf2d_div
  import kf2d_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     go,
  input  wire logic signed [DATA_W-1:0] num,
  input  wire logic signed [DATA_W-1:0] den,
  output logic signed [DATA_W-1:0]      quo,
  output logic                          done
);

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);
  localparam logic [QUO_W:0] POS_MAX = (QUO_W+1)'((64'd1 << (DATA_W - 1)) - 64'd1);
  localparam logic [QUO_W:0] NEG_MAX = (QUO_W+1)'(64'd1 << (DATA_W - 1));

  logic               busy_r, fin_r, done_r, neg_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DATA_W:0]    rem_r;
  logic [QUO_W-1:0]   dq_r;
  logic [DATA_W-1:0]  ud_r;
  logic signed [DATA_W-1:0] quo_r;

  logic [DATA_W:0]    r2;
  logic               ge;
  logic [DATA_W+1:0]  rem2;
  logic [QUO_W:0]     qm;
  logic [DATA_W-1:0]  qsat;
  logic [DATA_W-1:0]  un, udn;

  assign un  = num[DATA_W-1] ? (~num + 1'b1) : num;
  assign udn = den[DATA_W-1] ? (~den + 1'b1) : den;

  // restoring step, one quotient bit per cycle
  assign r2 = {rem_r[DATA_W-1:0], dq_r[QUO_W-1]};
  assign ge = (r2 >= {1'b0, ud_r});

  // round half away from zero, then sign and saturate
  assign rem2 = {rem_r, 1'b0};
  assign qm   = {1'b0, dq_r} + (QUO_W+1)'(rem2 >= {2'b00, ud_r});
  always_comb begin
    if (!neg_r) begin
      qsat = (qm > POS_MAX) ? POS_MAX[DATA_W-1:0] : qm[DATA_W-1:0];
    end else begin
      qsat = (qm > NEG_MAX) ? NEG_MAX[DATA_W-1:0] : (~qm[DATA_W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cnt_r <= '0;
      rem_r <= '0;
      dq_r  <= {un, {FRAC_BITS{1'b0}}};
      ud_r  <= udn;
      neg_r <= num[DATA_W-1] ^ den[DATA_W-1];
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= ge ? (r2 - {1'b0, ud_r}) : r2;
      dq_r  <= {dq_r[QUO_W-2:0], ge};
    end
    if (fin_r) begin
      quo_r <= qsat;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== rtl/core/kf2d_datapath.sv =====
`default_nettype none
module kf2d_datapath
  import kf2d_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dp_cmd_t                  cmd,
  output dp_sts_t                       sts,
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_wdata,
  input  wire logic                     in_has_detection,
  input  wire logic signed [DATA_W-1:0] in_meas_x,
  input  wire logic signed [DATA_W-1:0] in_meas_y,
  output logic signed [DATA_W-1:0]      out_est_x,
  output logic signed [DATA_W-1:0]      out_est_y,
  output logic signed [DATA_W-1:0]      out_cov_xx,
  output logic signed [DATA_W-1:0]      out_cov_xy,
  output logic signed [DATA_W-1:0]      out_cov_yx,
  output logic signed [DATA_W-1:0]      out_cov_yy,
  output logic                          out_singular
);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (DATA_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(64'sd1 <<< (DATA_W - 1)));
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

  // filter state and configuration
  logic signed [DATA_W-1:0] x0_r, x1_r, p0_r, p1_r, p2_r, p3_r;
  logic signed [DATA_W-1:0] a0_r, a1_r, a2_r, a3_r, qx_r, qy_r, rx_r, ry_r;
  // scratch
  logic signed [DATA_W-1:0] m0_r, m1_r, m2_r, m3_r, s0_r, s1_r, s2_r, s3_r;
  logic signed [DATA_W-1:0] k0_r, k1_r, k2_r, k3_r, y0_r, y1_r, det_r, n_r;
  logic signed [DATA_W-1:0] z0_r, z1_r;
  logic                     det_req_r, sing_r;

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r, pclr_r, psub_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [DATA_W-1:0] opa, opb, rnd_val, wr_val, quo;
  logic signed [ACC_W-1:0]  rsum, rsh, pext, abase;
  logic                     wr_en, div_done;

  logic signed [DATA_W-1:0] oex_r, oey_r, oxx_r, oxy_r, oyx_r, oyy_r;
  logic                     osg_r;

  function automatic logic signed [DATA_W-1:0] rd(sel_t s,
    logic signed [DATA_W-1:0] x0, logic signed [DATA_W-1:0] x1,
    logic signed [DATA_W-1:0] p0, logic signed [DATA_W-1:0] p1,
    logic signed [DATA_W-1:0] p2, logic signed [DATA_W-1:0] p3,
    logic signed [DATA_W-1:0] m0, logic signed [DATA_W-1:0] m1,
    logic signed [DATA_W-1:0] m2, logic signed [DATA_W-1:0] m3,
    logic signed [DATA_W-1:0] s0, logic signed [DATA_W-1:0] s1,
    logic signed [DATA_W-1:0] s2, logic signed [DATA_W-1:0] s3,
    logic signed [DATA_W-1:0] k0, logic signed [DATA_W-1:0] k1,
    logic signed [DATA_W-1:0] k2, logic signed [DATA_W-1:0] k3,
    logic signed [DATA_W-1:0] y0, logic signed [DATA_W-1:0] y1,
    logic signed [DATA_W-1:0] z0, logic signed [DATA_W-1:0] z1,
    logic signed [DATA_W-1:0] a0, logic signed [DATA_W-1:0] a1,
    logic signed [DATA_W-1:0] a2, logic signed [DATA_W-1:0] a3,
    logic signed [DATA_W-1:0] qx, logic signed [DATA_W-1:0] qy,
    logic signed [DATA_W-1:0] rx, logic signed [DATA_W-1:0] ry);
    logic signed [DATA_W-1:0] v;
    case (s)
      R_X0: v = x0;  R_X1: v = x1;
      R_P0: v = p0;  R_P1: v = p1;  R_P2: v = p2;  R_P3: v = p3;
      R_M0: v = m0;  R_M1: v = m1;  R_M2: v = m2;  R_M3: v = m3;
      R_S0: v = s0;  R_S1: v = s1;  R_S2: v = s2;  R_S3: v = s3;
      R_K0: v = k0;  R_K1: v = k1;  R_K2: v = k2;  R_K3: v = k3;
      R_Y0: v = y0;  R_Y1: v = y1;  R_Z0: v = z0;  R_Z1: v = z1;
      R_A0: v = a0;  R_A1: v = a1;  R_A2: v = a2;  R_A3: v = a3;
      R_QX: v = qx;  R_QY: v = qy;  R_RX: v = rx;  R_RY: v = ry;
      default: v = ONE_FX;
    endcase
    return v;
  endfunction

  assign opa = rd(cmd.sel_a, x0_r, x1_r, p0_r, p1_r, p2_r, p3_r, m0_r, m1_r, m2_r,
                  m3_r, s0_r, s1_r, s2_r, s3_r, k0_r, k1_r, k2_r, k3_r, y0_r, y1_r,
                  z0_r, z1_r, a0_r, a1_r, a2_r, a3_r, qx_r, qy_r, rx_r, ry_r);
  assign opb = rd(cmd.sel_b, x0_r, x1_r, p0_r, p1_r, p2_r, p3_r, m0_r, m1_r, m2_r,
                  m3_r, s0_r, s1_r, s2_r, s3_r, k0_r, k1_r, k2_r, k3_r, y0_r, y1_r,
                  z0_r, z1_r, a0_r, a1_r, a2_r, a3_r, qx_r, qy_r, rx_r, ry_r);

  // multiply, registered, then accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mac_en;
    end
  end

  assign pext  = ACC_W'(prod_r);
  assign abase = pclr_r ? '0 : acc_r;

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    pclr_r <= cmd.mac_clr;
    psub_r <= cmd.mac_sub;
    if (pv_r) begin
      acc_r <= psub_r ? (abase - pext) : (abase + pext);
    end
  end

  // round to nearest, ties up, and saturate
  assign rsum = acc_r + RND;
  assign rsh  = rsum >>> FRAC_BITS;
  always_comb begin
    if (rsh > SAT_HI) begin
      rnd_val = SAT_HI[DATA_W-1:0];
    end else if (rsh < SAT_LO) begin
      rnd_val = SAT_LO[DATA_W-1:0];
    end else begin
      rnd_val = rsh[DATA_W-1:0];
    end
  end

  kf2d_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .num   (n_r),
    .den   (det_r),
    .quo   (quo),
    .done  (div_done)
  );

  assign wr_en  = cmd.st_en | div_done;
  assign wr_val = div_done ? quo : rnd_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r <= '0;      x1_r <= '0;
      p0_r <= ONE_FX;  p1_r <= '0;  p2_r <= '0;  p3_r <= ONE_FX;
      a0_r <= ONE_FX;  a1_r <= '0;  a2_r <= '0;  a3_r <= ONE_FX;
      qx_r <= TENTH_FX; qy_r <= TENTH_FX;
      rx_r <= ONE_FX;  ry_r <= ONE_FX;
      sing_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TRANS_XX: a0_r <= cfg_wdata;
          CFG_TRANS_XY: a1_r <= cfg_wdata;
          CFG_TRANS_YX: a2_r <= cfg_wdata;
          CFG_TRANS_YY: a3_r <= cfg_wdata;
          CFG_PNOISE_X: qx_r <= {1'b0, cfg_wdata[DATA_W-2:0]};
          CFG_PNOISE_Y: qy_r <= {1'b0, cfg_wdata[DATA_W-2:0]};
          CFG_MNOISE_X: rx_r <= {1'b0, cfg_wdata[DATA_W-2:0]};
          CFG_MNOISE_Y: ry_r <= {1'b0, cfg_wdata[DATA_W-2:0]};
          default: ;
        endcase
      end
      if (cmd.load_in) begin
        sing_r <= 1'b0;
      end else if (cmd.sing_set) begin
        sing_r <= 1'b1;
      end
      if (wr_en) begin
        case (cmd.wr_sel)
          R_X0: x0_r <= wr_val;
          R_X1: x1_r <= wr_val;
          R_P0: p0_r <= wr_val;
          R_P1: p1_r <= wr_val;
          R_P2: p2_r <= wr_val;
          R_P3: p3_r <= wr_val;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      z0_r      <= in_meas_x;
      z1_r      <= in_meas_y;
      det_req_r <= in_has_detection;
    end
    if (wr_en) begin
      case (cmd.wr_sel)
        R_M0:  m0_r  <= wr_val;
        R_M1:  m1_r  <= wr_val;
        R_M2:  m2_r  <= wr_val;
        R_M3:  m3_r  <= wr_val;
        R_S0:  s0_r  <= wr_val;
        R_S1:  s1_r  <= wr_val;
        R_S2:  s2_r  <= wr_val;
        R_S3:  s3_r  <= wr_val;
        R_K0:  k0_r  <= wr_val;
        R_K1:  k1_r  <= wr_val;
        R_K2:  k2_r  <= wr_val;
        R_K3:  k3_r  <= wr_val;
        R_Y0:  y0_r  <= wr_val;
        R_Y1:  y1_r  <= wr_val;
        R_DET: det_r <= wr_val;
        R_N:   n_r   <= wr_val;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      oex_r <= x0_r;  oey_r <= x1_r;
      oxx_r <= p0_r;  oxy_r <= p1_r;  oyx_r <= p2_r;  oyy_r <= p3_r;
      osg_r <= sing_r;
    end
  end

  assign sts.det_req  = det_req_r;
  assign sts.det_zero = (det_r == '0);
  assign sts.div_done = div_done;

  assign out_est_x    = oex_r;
  assign out_est_y    = oey_r;
  assign out_cov_xx   = oxx_r;
  assign out_cov_xy   = oxy_r;
  assign out_cov_yx   = oyx_r;
  assign out_cov_yy   = oyy_r;
  assign out_singular = osg_r;

endmodule
`default_nettype wire

// ===== rtl/core/kf2d_ctrl.sv =====
`default_nettype none
module kf2d_ctrl
  import kf2d_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISP, ST_TERM, ST_DRAIN, ST_STORE, ST_DIVGO, ST_DIVWAIT, ST_OUT
  } state_t;

  state_t     state_r, state_nxt;
  upc_t       pc_r, pc_nxt;
  logic [1:0] tc_r, tc_nxt;
  logic       ov_r, ov_nxt;
  uop_t       u;

  assign u = ucode(pc_r);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    tc_nxt    = tc_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.sel_a  = R_ONE;
    cmd.sel_b  = R_ONE;
    cmd.wr_sel = u.dst;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          pc_nxt      = '0;
          state_nxt   = ST_DISP;
        end
      end
      ST_DISP: begin
        case (u.kind)
          U_ACC, U_KDIV: begin
            tc_nxt    = '0;
            state_nxt = ST_TERM;
          end
          U_BR_NODET: pc_nxt = sts.det_req ? (pc_r + 1'b1) : UPC_END;
          U_BR_SING: begin
            if (sts.det_zero) begin
              cmd.sing_set = 1'b1;
              pc_nxt       = UPC_END;
            end else begin
              pc_nxt = pc_r + 1'b1;
            end
          end
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_TERM: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_clr = (tc_r == 2'd0);
        cmd.mac_sub = u.sub[tc_r];
        case (tc_r)
          2'd0:    begin cmd.sel_a = u.a0; cmd.sel_b = u.b0; end
          2'd1:    begin cmd.sel_a = u.a1; cmd.sel_b = u.b1; end
          default: begin cmd.sel_a = u.a2; cmd.sel_b = u.b2; end
        endcase
        if (tc_r == u.nterm - 2'd1) begin
          state_nxt = ST_DRAIN;
        end else begin
          tc_nxt = tc_r + 2'd1;
        end
      end
      ST_DRAIN: state_nxt = ST_STORE;
      ST_STORE: begin
        cmd.st_en = 1'b1;
        if (u.kind == U_KDIV) begin
          cmd.wr_sel = R_N;
          state_nxt  = ST_DIVGO;
        end else begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_DISP;
        end
      end
      ST_DIVGO: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_DIVWAIT;
      end
      ST_DIVWAIT: begin
        if (sts.div_done) begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_DISP;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      tc_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      tc_r    <= tc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;

endmodule
`default_nettype wire

// ===== rtl/core/kalman_filter_2d_position.sv =====
// Two-state Kalman filter on a 2D position, signed Q16.16 throughout.
// Input channel (in_valid/in_ready): one word per frame with has_detection
// and the measured center. Every word runs predict; a detection adds update.
// Output channel (out_valid/out_ready): one word per input word with the
// estimate, the full covariance and the singular flag.
// Every word runs on the single shared 32x32 multiply-accumulate (dispatch,
// one product per cycle, a drain step and a store step per entry); a word
// with a detection also uses the bit-serial divider for each of the four
// gain entries.
// One word is in flight at a time; the next is taken once the previous
// result has moved into the output register, even if that result still
// waits.
// If the receiver stalls, the result holds in the output register and the
// block holds its finished work until the register frees up.
// Reset (synchronous, rst_n low): estimate zero, covariance identity, and
// the registers back to A=I, Q=0.1*I, R=I.
// Config (cfg_we/cfg_index/cfg_wdata) writes take effect at once; write only
// while no word is in flight.
`default_nettype none
module kalman_filter_2d_position
  import kf2d_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_has_detection,
  input  wire logic signed [DATA_W-1:0] in_meas_x,
  input  wire logic signed [DATA_W-1:0] in_meas_y,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_est_x,
  output logic signed [DATA_W-1:0]      out_est_y,
  output logic signed [DATA_W-1:0]      out_cov_xx,
  output logic signed [DATA_W-1:0]      out_cov_xy,
  output logic signed [DATA_W-1:0]      out_cov_yx,
  output logic signed [DATA_W-1:0]      out_cov_yy,
  output logic                          out_singular,
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_wdata
);

  dp_cmd_t cmd;   // sequencer -> datapath
  dp_sts_t sts;   // datapath -> sequencer

  // microcoded sequencer: walks the predict/update program
  kf2d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // register file, shared MAC, divider, output word register
  kf2d_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_has_detection (in_has_detection),
    .in_meas_x        (in_meas_x),
    .in_meas_y        (in_meas_y),
    .out_est_x        (out_est_x),
    .out_est_y        (out_est_y),
    .out_cov_xx       (out_cov_xx),
    .out_cov_xy       (out_cov_xy),
    .out_cov_yx       (out_cov_yx),
    .out_cov_yy       (out_cov_yy),
    .out_singular     (out_singular)
  );

endmodule
`default_nettype wire
